/* src/f32pr_pkg.sv */
// Shared constants, types and decode values for the float32 precision reducer.
package f32pr_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned FracBits = 23;
  localparam int unsigned ExpBits  = 8;
  localparam int unsigned EwW      = 4;
  localparam int unsigned FwW      = 5;
  localparam int unsigned AddrW    = 3;

  localparam logic [7:0]        ExpField = 8'hFF;
  localparam logic [7:0]        F32Bias  = 8'd127;
  localparam logic [WordW-1:0]  SignMask = 32'h8000_0000;
  localparam logic [WordW-1:0]  InfBits  = 32'h7F80_0000;

  localparam logic [EwW-1:0] EwReset = 4'd8;
  localparam logic [FwW-1:0] FwReset = 5'd23;

  // Register index taken from paddr[2]
  localparam logic REG_EXP_WIDTH  = 1'b0;
  localparam logic REG_FRAC_WIDTH = 1'b1;

  typedef struct packed {
    logic [EwW-1:0] exp_width;
    logic [FwW-1:0] frac_width;
  } cfg_t;

endpackage

/* src/f32pr_reduce.sv */
// Combinational round-to-nearest-even and exponent clamp for one float32 word.
module f32pr_reduce (
  input  logic [31:0]     word_in,
  input  f32pr_pkg::cfg_t cfg,
  output logic [31:0]     word_out
);
  import f32pr_pkg::*;

  logic [4:0]       keep;
  logic [4:0]       drop;
  logic [WordW-1:0] half;
  logic [WordW-1:0] low_mask;
  logic [WordW-1:0] tail;
  logic             lsb;
  logic             up;
  logic [WordW-1:0] rounded;
  logic [2:0]       ew_m1;
  logic [7:0]       bias;
  logic [7:0]       max_e;
  logic [7:0]       min_e;
  logic [7:0]       e;

  always_comb begin
    // rounding: widths above 23 saturate
    keep     = (cfg.frac_width > 5'(FracBits)) ? 5'(FracBits) : cfg.frac_width;
    drop     = 5'(FracBits) - keep;
    half     = (drop == 5'd0) ? '0 : (32'd1 << (drop - 5'd1));
    low_mask = (32'd1 << drop) - 32'd1;
    tail     = word_in & low_mask;
    lsb      = |(word_in & (32'd1 << drop));
    up       = (tail > half) || ((tail == half) && lsb);
    if (drop == 5'd0) begin
      rounded = word_in;
    end else begin
      rounded = (up ? (word_in + half) : word_in) & ~low_mask;
    end

    // exponent clamp on the rounded word; zero width acts as one
    ew_m1 = (cfg.exp_width == 4'd0) ? 3'd0 : 3'(cfg.exp_width - 4'd1);
    bias  = (8'd1 << ew_m1) - 8'd1;
    max_e = bias + F32Bias;
    min_e = (F32Bias + 8'd1) - bias;
    e     = rounded[FracBits +: ExpBits];

    word_out = rounded;
    if (cfg.exp_width < 4'(ExpBits) && e != ExpField && e != 8'd0) begin
      if (e > max_e) begin
        word_out = (rounded & SignMask) | InfBits;
      end else if (e < min_e) begin
        word_out = rounded & SignMask;
      end
    end
  end

endmodule

/* src/float32_precision_reducer_core.sv */
// Top level: stream wrapper, config registers and two-stage pipeline of the reducer.
//
// Usage notes
// - in_*: one float32 word per handshake (in_tvalid && in_tready), tdata = value_word.
// - out_*: one reduced word per input word, same order, tdata = reduced_word.
// - cfg_*: APB-style port. 0x0 exponent_width (4 bits), 0x4 frac_width (5 bits).
//   pready is tied high; writes land on the access cycle. Write only while idle.
// - Path: an accepted input goes into the input register, then through the
//   round/clamp logic into the output register, which drives out_tvalid.
// - Throughput: one word per cycle while out_tready is high, set by the single-pass
//   round/clamp path between the two registers.
// - Stall: when out_tready is low the output register holds its word; the input
//   register still takes one more word, then in_tready drops until the output
//   drains.
// - Reset (rst_n low, synchronous): both stages empty, exponent_width = 8,
//   fraction_width = 23, so words pass unchanged until configured.
module float32_precision_reducer_core (
  input  logic                       clk,
  input  logic                       rst_n,
  // input stream
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [31:0]                in_tdata,   // [31:0] value_word
  // result stream
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [31:0]                out_tdata,  // [31:0] reduced_word
  // config port
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [f32pr_pkg::AddrW-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);
  import f32pr_pkg::*;

  cfg_t        cfg_r, cfg_nxt;
  logic        s1_vld_r, s1_vld_nxt;
  logic [31:0] s1_word_r;
  logic        out_vld_r, out_vld_nxt;
  logic [31:0] out_word_r;
  logic [31:0] reduced;
  logic        out_free;
  logic        s1_adv;
  logic        in_acc;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // register writes, low bits of pwdata only
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_EXP_WIDTH:  cfg_nxt.exp_width  = cfg_pwdata[EwW-1:0];
        REG_FRAC_WIDTH: cfg_nxt.frac_width = cfg_pwdata[FwW-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_EXP_WIDTH:  cfg_prdata = {{(32-EwW){1'b0}}, cfg_r.exp_width};
      REG_FRAC_WIDTH: cfg_prdata = {{(32-FwW){1'b0}}, cfg_r.frac_width};
      default:        cfg_prdata = '0;
    endcase
  end

  // pipeline control: output slot frees on take, input slot moves when output frees
  assign out_free   = !out_vld_r || out_tready;
  assign s1_adv     = s1_vld_r && out_free;
  assign in_tready  = !s1_vld_r || out_free;
  assign in_acc     = in_tvalid && in_tready;

  always_comb begin
    s1_vld_nxt  = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_vld_r);
    out_vld_nxt = s1_adv ? 1'b1 : (out_tready ? 1'b0 : out_vld_r);
  end

  f32pr_reduce u_reduce (
    .word_in  (s1_word_r),
    .cfg      (cfg_r),
    .word_out (reduced)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.exp_width  <= EwReset;
      cfg_r.frac_width <= FwReset;
      s1_vld_r         <= 1'b0;
      out_vld_r        <= 1'b0;
    end else begin
      cfg_r     <= cfg_nxt;
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_word_r <= in_tdata;
    end
    if (s1_adv) begin
      out_word_r <= reduced;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_word_r;

  // a held input word is not lost or overwritten while the output is blocked
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !out_free) |=> (s1_vld_r && $stable(s1_word_r)))
    else $error("input stage lost its word during stall");

  // an accepted word always lands in the input stage
  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_vld_r)
    else $error("accepted word not captured");

  // with full widths the word passes unchanged
  a_passthru: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && cfg_r.exp_width >= 4'(ExpBits) && cfg_r.frac_width >= 5'(FracBits))
    |=> (out_tvalid && out_tdata == $past(s1_word_r)))
    else $error("full-width word altered");

endmodule

/* sim/tb.sv */
// Self-checking testbench for the float32 precision reducer: streams words, checks results.
module tb;
  import f32pr_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int DrainCycles = 6;
  localparam logic [AddrW-1:0] ADDR_EXP_WIDTH  = {REG_EXP_WIDTH, 2'b00};
  localparam logic [AddrW-1:0] ADDR_FRAC_WIDTH = {REG_FRAC_WIDTH, 2'b00};

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [31:0]      in_tdata = '0;     // [31:0] value_word
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [31:0]      out_tdata;         // [31:0] reduced_word
  logic             cfg_psel = 1'b0;
  logic             cfg_penable = 1'b0;
  logic             cfg_pwrite = 1'b0;
  logic [AddrW-1:0] cfg_paddr = '0;
  logic [31:0]      cfg_pwdata = '0;
  logic [31:0]      cfg_prdata;
  logic             cfg_pready;

  float32_precision_reducer_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  // Shadow copy of the two registers, updated on the write edge
  logic [EwW-1:0] ew_shadow = EwReset;
  logic [FwW-1:0] fw_shadow = FwReset;

  logic [31:0] value_pending[$];   // words waiting for the driver
  logic [31:0] reduced_due[$];     // predicted results, oldest first
  int          words_queued = 0;
  int          words_taken = 0;
  int          mismatches = 0;
  int          cycles = 0;
  bit          calm = 1'b0;        // no idling on either side while set
  int          tx_wait = 0;
  int          rx_wait = 0;

  // Round-to-nearest-even on the dropped fraction bits, then exponent clamp
  function automatic logic [31:0] reduce_word(logic [31:0] w, logic [EwW-1:0] ew_reg,
                                              logic [FwW-1:0] fw_reg);
    int unsigned keep, drop, ew, bias, max_e, min_e;
    logic [31:0] half, low_mask, tail, r;
    logic [7:0]  e;
    r = w;
    keep = (fw_reg > FracBits) ? FracBits : fw_reg;
    if (keep < FracBits) begin
      drop = FracBits - keep;
      half = 32'd1 << (drop - 1);
      low_mask = (32'd1 << drop) - 32'd1;
      tail = r & low_mask;
      if (tail > half || (tail == half && r[drop]))
        r = r + half;              // may carry into exponent or wrap past sign
      r = r & ~low_mask;
    end
    ew = (ew_reg == 0) ? 1 : ew_reg;
    if (ew < ExpBits) begin
      bias = (1 << (ew - 1)) - 1;
      max_e = bias + F32Bias;
      min_e = F32Bias + 1 - bias;
      e = r[30:23];
      // exponent 0 and 255 pass untouched, even when rounding produced them
      if (e != ExpField && e != 8'd0) begin
        if (e > max_e)
          r = (r & SignMask) | InfBits;
        else if (e < min_e)
          r = r & SignMask;
      end
    end
    return r;
  endfunction

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 5);
  endfunction

  // Random word biased toward the interesting spots of the current format
  function automatic logic [31:0] make_word();
    int unsigned ew, bias, max_e, min_e, keep, drop, pick;
    logic [31:0] w, half, low_mask;
    logic [7:0]  e;
    ew = (ew_shadow == 0) ? 1 : ((ew_shadow > ExpBits) ? ExpBits : ew_shadow);
    bias = (1 << (ew - 1)) - 1;
    max_e = bias + F32Bias;
    min_e = F32Bias + 1 - bias;
    keep = (fw_shadow > FracBits) ? FracBits : fw_shadow;
    w = $urandom();
    pick = $urandom_range(0, 9);
    if (pick == 4 || pick == 5) begin
      // exponent right at the overflow or underflow edge
      e = (pick == 4) ? 8'(max_e + $urandom_range(0, 2) - 1) :
                        8'(min_e + $urandom_range(0, 2) - 1);
      w[30:23] = e;
    end else if ((pick == 6 || pick == 7) && keep < FracBits) begin
      // dropped bits at, just under or just over the halfway point
      drop = FracBits - keep;
      half = 32'd1 << (drop - 1);
      low_mask = (32'd1 << drop) - 32'd1;
      w = (w & ~low_mask) | ((half + $urandom_range(0, 2) - 1) & low_mask);
    end else if (pick == 8) begin
      w[30:23] = $urandom_range(0, 1) ? ExpField : 8'd0;
      if ($urandom_range(0, 1)) w[22:0] = '1;
    end else if (pick == 9) begin
      w[22:0] = '1;                // long carry ripple
    end
    return w;
  endfunction

  // Input side: per-word gap, valid held until the handshake
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      tx_wait <= draw_wait();
    end else if (in_tvalid && !in_tready) begin
      // hold the word
    end else if (tx_wait != 0) begin
      in_tvalid <= 1'b0;
      tx_wait <= tx_wait - 1;
    end else if (value_pending.size() != 0) begin
      in_tvalid <= 1'b1;
      in_tdata <= value_pending.pop_front();
      tx_wait <= draw_wait();
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Predict on every accepted input word
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      reduced_due.push_back(reduce_word(in_tdata, ew_shadow, fw_shadow));
      words_taken = words_taken + 1;
    end
  end

  // Result side: check against the oldest prediction, then stall at random
  always @(posedge clk) begin : rx_side
    int w;
    logic [31:0] want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_wait <= 0;
    end else if (out_tvalid && out_tready) begin
      if (reduced_due.size() == 0) begin
        $error("reduced_word: no word expected, got %h", out_tdata);
        mismatches = mismatches + 1;
      end else begin
        want = reduced_due.pop_front();
        if (out_tdata !== want) begin
          $error("reduced_word: expected %h, got %h", want, out_tdata);
          mismatches = mismatches + 1;
        end
      end
      w = draw_wait();
      rx_wait <= w;
      out_tready <= (w == 0);
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      out_tready <= (rx_wait == 1);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic cfg_access(input logic wr, input logic [AddrW-1:0] addr,
                            input logic [31:0] data, output logic [31:0] rdata);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic cfg_check(input logic [AddrW-1:0] addr, input logic [31:0] want,
                           input string field);
    logic [31:0] got;
    cfg_access(1'b0, addr, '0, got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", field, want, got);
      mismatches = mismatches + 1;
    end
  endtask

  // Upper data bits are sometimes junk; the register keeps its low bits only
  task automatic set_format(input logic [EwW-1:0] ew_val, input logic [FwW-1:0] fw_val);
    logic [31:0] hi, rd;
    hi = ($urandom_range(0, 3) == 0) ? $urandom() : 32'd0;
    cfg_access(1'b1, ADDR_EXP_WIDTH, {hi[31:EwW], ew_val}, rd);
    ew_shadow = ew_val;
    hi = ($urandom_range(0, 3) == 0) ? $urandom() : 32'd0;
    cfg_access(1'b1, ADDR_FRAC_WIDTH, {hi[31:FwW], fw_val}, rd);
    fw_shadow = fw_val;
    cfg_check(ADDR_EXP_WIDTH, 32'(ew_val), "exponent_width");
    cfg_check(ADDR_FRAC_WIDTH, 32'(fw_val), "fraction_width");
  endtask

  task automatic push_word(input logic [31:0] w);
    value_pending.push_back(w);
    words_queued = words_queued + 1;
  endtask

  // Idle once every queued word went in and every prediction came back
  task automatic wait_drained();
    while (words_taken != words_queued || reduced_due.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic random_phase(input int n_words);
    calm = ($urandom_range(0, 3) == 0);
    repeat (n_words) push_word(make_word());
    wait_drained();
  endtask

  initial begin : stimulus
    logic [31:0] directed[$];
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset format passes words unchanged
    cfg_check(ADDR_EXP_WIDTH, 32'(EwReset), "exponent_width");
    cfg_check(ADDR_FRAC_WIDTH, 32'(FwReset), "fraction_width");
    random_phase(30);

    // half-precision layout: 5 exponent bits, 10 fraction bits
    set_format(4'd5, 5'd10);
    directed = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                 32'h7FFF_FFFF,   // NaN carrying into the sign bit
                 32'hFFFF_FFFF,   // carry wraps past the sign bit
                 32'h7F80_0001,   // NaN payload masked away
                 32'h3F80_0000,
                 32'h3F80_1000,   // tie, even: round down
                 32'h3F80_3000,   // tie, odd: round up
                 32'h3F80_1001, 32'h3F80_0FFF,
                 32'h477F_F000,   // rounds up past the reduced maximum
                 32'h4780_0000, 32'hC780_0000,
                 32'h3880_0000,   // smallest kept exponent
                 32'h3800_0000, 32'hB800_0000,
                 32'h0000_0001,
                 32'h007F_FFFF,   // subnormal rounds into a clampable exponent
                 32'h7F7F_FFFF,   // rounds into exponent 255, left alone
                 32'h5A5A_5A5A, 32'hA5A5_A5A5};
    calm = 1'b0;
    foreach (directed[i]) push_word(directed[i]);
    wait_drained();

    // extremes and out-of-range register values, then random formats
    set_format(4'd1, 5'd0);   random_phase(70);
    set_format(4'd0, 5'd0);   random_phase(70);
    set_format(4'd15, 5'd31); random_phase(70);
    set_format(4'd9, 5'd24);  random_phase(60);
    set_format(4'd8, 5'd7);   random_phase(70);
    set_format(4'd8, 5'd23);  random_phase(40);
    set_format(4'd7, 5'd22);  random_phase(60);
    repeat (7) begin
      set_format(4'($urandom_range(0, 15)), 5'($urandom_range(0, 31)));
      random_phase(60);
    end

    wait_drained();
    if (mismatches == 0 && reduced_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
